>>> rtl/core/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// No dependencies; imported by the sequencer and the top level.
`timescale 1ns / 1ps

package spq_pkg;

  // Command codes carried in the input item.
  localparam logic [1:0] CMD_ENQ       = 2'd0;
  localparam logic [1:0] CMD_DEQ_HEAD  = 2'd1;
  localparam logic [1:0] CMD_DEQ_EXACT = 2'd2;
  localparam logic [1:0] CMD_DEQ_MIN   = 2'd3;

  // Status codes carried in the result item.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_PRIORITY = 2'd1;
  localparam logic [1:0] ST_FULL         = 2'd2;
  localparam logic [1:0] ST_NONE         = 2'd3;

  // One decoded input item.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  priority_req;
    logic [31:0] payload;
  } spq_req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_priority;
    logic [31:0] out_payload;
    logic [4:0]  entry_total;
    logic        head_valid;
    logic [7:0]  head_priority;
    logic [31:0] head_payload;
  } spq_res_t;

endpackage

>>> rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: stream ports and result register.
// Depends on spq_pkg and spq_seq.
`timescale 1ns / 1ps

// Channel  Direction  Data bits  Contents
// s_axis   in         48         cmd, priority_req, payload
// m_axis   out        88         status, out_priority, out_payload, entry_total,
//                                head_valid, head_priority, head_payload
//
// One item at a time; a single RAM read port is walked one entry at a time.
// Enqueue works back from the tail, moving up k entries of lower priority.
// Dequeue scans s entries from the head, then moves m later entries down.
// Reset (rst, synchronous) empties the queue at once; no clearing pass.
// A result waits in the output register while the next item is worked on.

module stable_priority_queue #(
  parameter int DEPTH        = 16,
  parameter int MAX_PRIORITY = 255,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], priority_req[9:2], payload[41:10], zero fill [47:42]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_priority[9:2], out_payload[41:10], entry_total[46:42],
  // head_valid[47], head_priority[55:48], head_payload[87:56]
  output logic [87:0] m_axis_tdata
);
  import spq_pkg::*;

  spq_req_t req;
  spq_res_t res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid;
  spq_res_t out_res;

  // Unpack the input item.
  assign req.cmd          = s_axis_tdata[1:0];
  assign req.priority_req = s_axis_tdata[9:2];
  assign req.payload      = s_axis_tdata[41:10];

  spq_seq #(
    .DEPTH       (DEPTH),
    .MAX_PRIORITY(MAX_PRIORITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_axis_tvalid),
    .req_ready(s_axis_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Output register takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  // Pack the result item.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.head_payload, out_res.head_priority, out_res.head_valid,
                          out_res.entry_total, out_res.out_payload, out_res.out_priority,
                          out_res.status};

endmodule

>>> rtl/core/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the queue entries.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/spq_seq.sv
// Sequencer of the stable priority queue: walks the sorted entry RAM with one
// shared priority comparator, shifting one entry per step.
// Depends on spq_pkg and spq_ram.
`timescale 1ns / 1ps

module spq_seq #(
  parameter int DEPTH        = 16,
  parameter int MAX_PRIORITY = 255,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  spq_pkg::spq_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output spq_pkg::spq_res_t res
);
  import spq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CW1 = CW + 1;
  localparam int PW  = PAYLOAD_BITS;
  localparam int EW  = 8 + PW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_EV   = 4'd3;
  localparam logic [3:0] S_INS_HEAD = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_EV  = 4'd6;
  localparam logic [3:0] S_SH_RD    = 4'd7;
  localparam logic [3:0] S_SH_WR    = 4'd8;
  localparam logic [3:0] S_HEAD_RD  = 4'd9;
  localparam logic [3:0] S_HEAD_EV  = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]    state;
  logic [1:0]    cmd;
  logic [7:0]    key;
  logic [PW-1:0] pay;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic [1:0]    status;
  logic [7:0]    rprio;
  logic [PW-1:0] rpay;
  logic          hvalid;
  logic [7:0]    hprio;
  logic [PW-1:0] hpay;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [63:0]   pay_in_wide;
  logic [PW-1:0] pay_in;
  logic [7:0]    rd_prio;
  logic [PW-1:0] rd_pay;
  logic          cmp_ge;
  logic          cmp_eq;
  logic          scan_last;
  logic          scan_hit;
  logic          scan_stop;
  logic          more_after_hit;
  logic          more_shift;
  logic [63:0]   rpay_wide;
  logic [63:0]   hpay_wide;
  logic [8:0]    count_wide;

  spq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Incoming payload keeps its low PAYLOAD_BITS bits.
  assign pay_in_wide = 64'(req.payload);
  assign pay_in      = pay_in_wide[PW-1:0];

  // Shared comparator between the entry just read and the key.
  assign rd_prio = ram_rdata[EW-1:PW];
  assign rd_pay  = ram_rdata[PW-1:0];
  assign cmp_ge  = (rd_prio >= key);
  assign cmp_eq  = (rd_prio == key);

  // Scan and shift decisions.
  assign scan_last      = ((CW1'(idx) + CW1'(1)) == CW1'(count));
  assign scan_hit       = (cmd == CMD_DEQ_HEAD) || ((cmd == CMD_DEQ_MIN) && cmp_ge) ||
                          ((cmd == CMD_DEQ_EXACT) && cmp_eq);
  assign scan_stop      = (cmd != CMD_DEQ_EXACT) || !cmp_ge || scan_last;
  assign more_after_hit = ((CW1'(idx) + CW1'(1)) < CW1'(count));
  assign more_shift     = ((CW1'(idx) + CW1'(2)) < CW1'(count));

  // RAM port control for each step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx + AW'(1);
    ram_wdata = {key, pay};
    ram_raddr = idx;
    unique case (state)
      S_CHECK: begin
        if ((cmd == CMD_ENQ) && (key <= 8'(MAX_PRIORITY)) && (count == '0)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end
      end
      S_INS_EV: begin
        ram_we    = 1'b1;
        ram_wdata = cmp_ge ? {key, pay} : ram_rdata;
      end
      S_INS_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      S_SH_RD: begin
        ram_raddr = idx + AW'(1);
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
      end
      S_HEAD_RD: begin
        ram_raddr = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd   <= req.cmd;
            key   <= req.priority_req;
            pay   <= pay_in;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          rprio <= '0;
          rpay  <= '0;
          idx   <= '0;
          if (cmd == CMD_ENQ) begin
            if (key > 8'(MAX_PRIORITY)) begin
              status <= ST_BAD_PRIORITY;
              state  <= S_HEAD_RD;
            end else if (CW1'(count) == CW1'(DEPTH)) begin
              status <= ST_FULL;
              state  <= S_HEAD_RD;
            end else if (count == '0) begin
              status <= ST_OK;
              count  <= CW'(1);
              state  <= S_HEAD_RD;
            end else begin
              status <= ST_OK;
              idx    <= AW'(count - CW'(1));
              state  <= S_INS_RD;
            end
          end else begin
            status <= ST_NONE;
            state  <= (count == '0) ? S_HEAD_RD : S_SCAN_RD;
          end
        end
        S_INS_RD: begin
          state <= S_INS_EV;
        end
        S_INS_EV: begin
          // Entry moved up one slot, or the new one placed behind it.
          if (cmp_ge) begin
            count <= count + CW'(1);
            state <= S_HEAD_RD;
          end else if (idx == '0) begin
            state <= S_INS_HEAD;
          end else begin
            idx   <= idx - AW'(1);
            state <= S_INS_RD;
          end
        end
        S_INS_HEAD: begin
          count <= count + CW'(1);
          state <= S_HEAD_RD;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (scan_hit) begin
            status <= ST_OK;
            rprio  <= rd_prio;
            rpay   <= rd_pay;
            if (more_after_hit) begin
              state <= S_SH_RD;
            end else begin
              count <= count - CW'(1);
              state <= S_HEAD_RD;
            end
          end else if (scan_stop) begin
            state <= S_HEAD_RD;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          idx <= idx + AW'(1);
          if (more_shift) begin
            state <= S_SH_RD;
          end else begin
            count <= count - CW'(1);
            state <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: begin
          if (count == '0) begin
            hvalid <= 1'b0;
            hprio  <= '0;
            hpay   <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_HEAD_EV;
          end
        end
        S_HEAD_EV: begin
          hvalid <= 1'b1;
          hprio  <= rd_prio;
          hpay   <= rd_pay;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result assembly.
  assign rpay_wide  = 64'(rpay);
  assign hpay_wide  = 64'(hpay);
  assign count_wide = 9'(count);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status        = status;
    res.out_priority  = rprio;
    res.out_payload   = rpay_wide[31:0];
    res.entry_total   = count_wide[4:0];
    res.head_valid    = hvalid;
    res.head_priority = hprio;
    res.head_payload  = hpay_wide[31:0];
  end

  // The store never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW1'(count) <= CW1'(DEPTH))
    else $error("entry count above depth");

  // An accepted item keeps the sequencer busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("sequencer ready right after accepting an item");

  // The reported head agrees with the entry count.
  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (hvalid == (count != '0)))
    else $error("head valid disagrees with entry count");

endmodule

>>> sim/stable_priority_queue_test.sv
// Self-checking testbench for the stable priority queue top level.
// Depends on spq_pkg and stable_priority_queue; a built-in queue predictor checks each result.
`timescale 1ns / 1ps

module stable_priority_queue_test;
  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int MAX_PRIORITY = 255;
  localparam int PAYLOAD_BITS = 32;
  localparam logic [31:0] PAYLOAD_MASK =
    (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PAYLOAD_BITS) - 32'd1);

  localparam int RANDOM_OPS   = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_PCT     = 37;
  // Items (and results) numbered in this window see no idling at all.
  localparam int STEADY_FROM  = 150;
  localparam int STEADY_TO    = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  stable_priority_queue #(
    .DEPTH(DEPTH),
    .MAX_PRIORITY(MAX_PRIORITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Commands waiting to be offered, and results owed by the queue.
  spq_req_t cmd_backlog[$];
  spq_res_t owed_results[$];
  spq_req_t offered_cmd;

  // Shadow copy of the sorted entries; index 0 is the head.
  logic [7:0]  shadow_prio [DEPTH];
  logic [31:0] shadow_pay  [DEPTH];
  int          shadow_count = 0;

  int cycle_count  = 0;
  int items_taken  = 0;
  int results_seen = 0;
  int error_count  = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic spq_req_t make_op(logic [1:0] code, logic [7:0] prio, logic [31:0] word);
    spq_req_t op;
    op.cmd          = code;
    op.priority_req = prio;
    op.payload      = word;
    return op;
  endfunction

  // Pull one entry out of the shadow store and close the gap behind it.
  function automatic void pull_entry(int pos, inout spq_res_t r);
    r.status       = ST_OK;
    r.out_priority = shadow_prio[pos];
    r.out_payload  = shadow_pay[pos];
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_prio[i] = shadow_prio[i + 1];
      shadow_pay[i]  = shadow_pay[i + 1];
    end
    shadow_count--;
  endfunction

  // Apply one command to the shadow store and return the result it owes.
  function automatic spq_res_t predict_queue_op(spq_req_t op);
    spq_res_t r;
    int       pos;
    r        = '0;
    r.status = ST_NONE;
    case (op.cmd)
      CMD_ENQ: begin
        if (int'(op.priority_req) > MAX_PRIORITY) begin
          r.status = ST_BAD_PRIORITY;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Equal priorities stay in arrival order: insert after all ties.
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= op.priority_req) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i - 1];
            shadow_pay[i]  = shadow_pay[i - 1];
          end
          shadow_prio[pos] = op.priority_req;
          shadow_pay[pos]  = op.payload & PAYLOAD_MASK;
          shadow_count++;
          r.status = ST_OK;
        end
      end
      CMD_DEQ_HEAD: begin
        if (shadow_count > 0) pull_entry(0, r);
      end
      CMD_DEQ_EXACT: begin
        // Sorted store: the scan can stop at the first lower priority.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] > op.priority_req) pos++;
        if (pos < shadow_count && shadow_prio[pos] == op.priority_req) pull_entry(pos, r);
      end
      default: begin
        if (shadow_count > 0 && shadow_prio[0] >= op.priority_req) pull_entry(0, r);
      end
    endcase
    r.entry_total = shadow_count[4:0];
    if (shadow_count > 0) begin
      r.head_valid    = 1'b1;
      r.head_priority = shadow_prio[0];
      r.head_payload  = shadow_pay[0];
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned seen);
    error_count++;
    if (error_count <= 10) begin
      $display("result %0d: %s expected %0h, got %0h", results_seen, what, want, seen);
    end
  endtask

  // Driver: offers the backlog one item at a time and predicts each accepted item.
  always @(posedge clk) begin
    logic hold_off;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        owed_results.push_back(predict_queue_op(offered_cmd));
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        hold_off = (items_taken >= STEADY_FROM && items_taken < STEADY_TO) ? 1'b0 :
                   ($urandom_range(99) < IDLE_PCT);
        if (cmd_backlog.size() > 0 && !hold_off) begin
          offered_cmd = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, offered_cmd.payload, offered_cmd.priority_req,
                            offered_cmd.cmd};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest owed one.
  always @(posedge clk) begin
    spq_res_t got;
    spq_res_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status        = m_axis_tdata[1:0];
        got.out_priority  = m_axis_tdata[9:2];
        got.out_payload   = m_axis_tdata[41:10];
        got.entry_total   = m_axis_tdata[46:42];
        got.head_valid    = m_axis_tdata[47];
        got.head_priority = m_axis_tdata[55:48];
        got.head_payload  = m_axis_tdata[87:56];
        if (owed_results.size() == 0) begin
          note_mismatch("unexpected result, data", 64'd0, m_axis_tdata[63:0]);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status)
            note_mismatch("status", 64'(want.status), 64'(got.status));
          if (got.out_priority !== want.out_priority)
            note_mismatch("out_priority", 64'(want.out_priority), 64'(got.out_priority));
          if (got.out_payload !== want.out_payload)
            note_mismatch("out_payload", 64'(want.out_payload), 64'(got.out_payload));
          if (got.entry_total !== want.entry_total)
            note_mismatch("entry_total", 64'(want.entry_total), 64'(got.entry_total));
          if (got.head_valid !== want.head_valid)
            note_mismatch("head_valid", 64'(want.head_valid), 64'(got.head_valid));
          if (got.head_priority !== want.head_priority)
            note_mismatch("head_priority", 64'(want.head_priority), 64'(got.head_priority));
          if (got.head_payload !== want.head_payload)
            note_mismatch("head_payload", 64'(want.head_payload), 64'(got.head_payload));
        end
        results_seen++;
      end
      m_axis_tready <= (results_seen >= STEADY_FROM && results_seen < STEADY_TO) ? 1'b1 :
                       ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int         random_ops;
    int         seg_num;
    int         seg_len;
    int         enq_pct;
    logic [7:0] pool [3];
    logic [7:0] pick;
    logic [1:0] op_code;
    logic [7:0] dir_prio;
    logic [31:0] dir_pay;

    // Dequeues of every kind on an empty queue.
    cmd_backlog.push_back(make_op(CMD_DEQ_HEAD, 8'd0, 32'h0));
    cmd_backlog.push_back(make_op(CMD_DEQ_EXACT, 8'd0, 32'hFFFF_FFFF));
    cmd_backlog.push_back(make_op(CMD_DEQ_MIN, 8'd0, 32'h0));
    // Fill to the brim with repeated priorities, including both extremes.
    for (int i = 0; i < DEPTH; i++) begin
      dir_prio = (i % 4 == 0) ? 8'd255 : (i % 4 == 1) ? 8'd0 : (i % 4 == 2) ? 8'd128 : 8'd200;
      dir_pay  = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
      cmd_backlog.push_back(make_op(CMD_ENQ, dir_prio, dir_pay));
    end
    // Full queue, then removals: first of a tie, a missing priority, head, threshold, exact zero.
    cmd_backlog.push_back(make_op(CMD_ENQ, 8'd77, 32'h1234_5678));
    cmd_backlog.push_back(make_op(CMD_DEQ_EXACT, 8'd128, 32'h0));
    cmd_backlog.push_back(make_op(CMD_DEQ_EXACT, 8'd77, 32'h0));
    cmd_backlog.push_back(make_op(CMD_DEQ_HEAD, 8'd255, 32'h0));
    cmd_backlog.push_back(make_op(CMD_DEQ_MIN, 8'd255, 32'h0));
    cmd_backlog.push_back(make_op(CMD_DEQ_EXACT, 8'd0, 32'h0));

    // Random segments alternate between filling and draining, drawing most
    // priorities from a small pool so that ties and exact hits are common.
    random_ops = 0;
    seg_num    = 0;
    while (random_ops < RANDOM_OPS) begin
      seg_len = $urandom_range(40, 15);
      enq_pct = (seg_num % 2 == 0) ? $urandom_range(85, 60) : $urandom_range(40, 15);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(5))
          0: pool[k] = 8'd0;
          1: pool[k] = 8'd255;
          default: pool[k] = 8'($urandom_range(255));
        endcase
      end
      for (int k = 0; k < seg_len && random_ops < RANDOM_OPS; k++) begin
        pick = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
               pool[2'($urandom_range(2))];
        if ($urandom_range(99) < enq_pct) begin
          op_code = CMD_ENQ;
        end else begin
          case ($urandom_range(2))
            0: op_code = CMD_DEQ_HEAD;
            1: op_code = CMD_DEQ_EXACT;
            default: op_code = CMD_DEQ_MIN;
          endcase
        end
        cmd_backlog.push_back(make_op(op_code, pick, $urandom()));
        random_ops++;
      end
      seg_num++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait on the falling edge so the checks see settled values.
    while ((cmd_backlog.size() > 0 || s_axis_tvalid || owed_results.size() > 0) &&
           cycle_count < CYCLE_LIMIT) begin
      @(negedge clk);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      error_count += owed_results.size();
      if (error_count == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule

>>> stable_priority_queue.f
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_seq.sv
rtl/core/stable_priority_queue.sv
sim/stable_priority_queue_test.sv
